/* rtl/piecewise_cubic_bezier_path_eval_macros.svh */
// Assertion macros for the cubic Bezier path evaluator.
// No dependencies; included by the top level.
`ifndef PIECEWISE_CUBIC_BEZIER_PATH_EVAL_MACROS_SVH
`define PIECEWISE_CUBIC_BEZIER_PATH_EVAL_MACROS_SVH
// Check an implication on every rising clock edge outside reset.
`define PCB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Check a next-cycle implication outside reset.
`define PCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/pcbpe_pkg.sv */
// Shared types and constants for the cubic Bezier path evaluator.
// No dependencies.
package pcbpe_pkg;
  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;
  // Segments held by the path store; the 4-bit segment field and the
  // 5-bit count register are sized for this value.
  localparam int unsigned MAX_SEG = 16;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;
  localparam logic [1:0] ST_BOTH = 2'd0;
  localparam logic [1:0] ST_POS  = 2'd1;
  localparam logic [1:0] ST_HELD = 2'd2;
  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;
endpackage

/* rtl/piecewise_cubic_bezier_path_eval.sv */
// Channel  | dir | contents
// s_axis   | in  | tdata {path_param,pt_z,pt_y,pt_x,point_index,segment}, tuser kind
// m_axis   | out | tdata {status,dir_z,dir_y,dir_x,pos_z,pos_y,pos_x}
// cfg      | in  | segment_count
// Pipeline: segment select and RAM read, three lerp levels, pose update driving the output.
// One transaction per cycle while the output is not stalled. Reset clears valids and pose.
// Every stage advances together on an enable; a stall freezes all stages.
// Depends on pcbpe_pkg, pcbpe_ram, pcbpe_lerp and the macros header.
`include "piecewise_cubic_bezier_path_eval_macros.svh"
module piecewise_cubic_bezier_path_eval
  import pcbpe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // segment[3:0], point_index[5:4], x[37:6], y[69:38], z[101:70], t[118:102]
  input  logic [119:0] s_axis_tdata,
  // kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos x,y,z [95:0], dir x,y,z [191:96], status [193:192]
  output logic [199:0] m_axis_tdata
);
  localparam int unsigned MaxSegments = MAX_SEG;
  localparam int unsigned SW = $clog2(MaxSegments);
  localparam int unsigned AW = SW + 2;
  localparam logic [FB:0] One = (FB+1)'(1 << FB);
  localparam logic [FB:0] Step = (FB+1)'(((1 << FB) + 50) / 100);
  localparam int unsigned NS = 5;

  logic [4:0] seg_cnt_q;
  logic [NS-1:0] vld_q;
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready || !(&vld_q[NS-1:NS-1]);
  // Stall whole pipe only when output holds a result
  logic stall;
  assign stall = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = !stall;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q <= '0;
    end else if (cfg_we_i) begin
      seg_cnt_q <= cfg_wdata_i;
    end
  end

  // Stage 0: decode
  logic [3:0] seg_in;
  logic [1:0] pi_in;
  logic [FB:0] t_in, nt;
  vec_t pt_in;
  assign seg_in = s_axis_tdata[3:0];
  assign pi_in = s_axis_tdata[5:4];
  assign pt_in = '{x: s_axis_tdata[37:6], y: s_axis_tdata[69:38], z: s_axis_tdata[101:70]};
  assign t_in = s_axis_tdata[118:102];
  assign nt = t_in + Step;
  logic [4:0] cnt;
  assign cnt = (seg_cnt_q > 5'(MaxSegments)) ? 5'(MaxSegments) : seg_cnt_q;
  logic [FB+5:0] sc0, sc1;
  assign sc0 = (FB+6)'(t_in) * (FB+6)'(cnt);
  assign sc1 = (FB+6)'(nt) * (FB+6)'(cnt);
  logic [SW-1:0] sa, sb;
  logic [FB:0] ua, ub;
  always_comb begin
    sa = SW'(sc0 >> FB);
    ua = {1'b0, sc0[FB-1:0]};
    if ((sc0 >> FB) >= cnt) begin
      sa = SW'(cnt - 5'd1);
      ua = One;
    end
    sb = SW'(sc1 >> FB);
    ub = {1'b0, sc1[FB-1:0]};
    if ((sc1 >> FB) >= cnt) begin
      sb = SW'(cnt - 5'd1);
      ub = One;
    end
  end
  logic ld_we;
  assign ld_we = acc && (s_axis_tuser == KIND_LOAD) && ({1'b0, seg_in} < 5'(MaxSegments));
  logic [1:0] st0;
  assign st0 = (cnt == 0 || t_in > One) ? ST_HELD : ((nt > One) ? ST_POS : ST_BOTH);

  // Eight RAMs: two copies for the two parameters, four points each
  vec_t cp_a [4];
  vec_t cp_b [4];
  for (genvar p = 0; p < 4; p++) begin : g_pt
    pcbpe_ram #(.Width(3*CW), .Depth(MaxSegments)) u_ra (
      .clk_i, .we_i(ld_we && pi_in == 2'(p)), .waddr_i(SW'(seg_in)), .wdata_i(pt_in),
      .re_i(en), .raddr_i(sa), .rdata_o(cp_a[p]));
    pcbpe_ram #(.Width(3*CW), .Depth(MaxSegments)) u_rb (
      .clk_i, .we_i(ld_we && pi_in == 2'(p)), .waddr_i(SW'(seg_in)), .wdata_i(pt_in),
      .re_i(en), .raddr_i(sb), .rdata_o(cp_b[p]));
  end

  logic [FB:0] ua_q [3];
  logic [FB:0] ub_q [3];
  logic [1:0] st_q [4];
  logic [NS-1:0] vld_d;
  assign vld_d = {vld_q[NS-2:0], acc && s_axis_tuser == KIND_EVAL};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en && !stall) begin
      vld_q <= vld_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      ua_q[0] <= ua; ub_q[0] <= ub; st_q[0] <= st0;
      for (int i = 1; i < 3; i++) begin
        ua_q[i] <= ua_q[i-1]; ub_q[i] <= ub_q[i-1];
      end
      for (int i = 1; i < 4; i++) st_q[i] <= st_q[i-1];
    end
  end

  vec_t la1 [3]; vec_t la2 [2]; vec_t la3 [1];
  vec_t lb1 [3]; vec_t lb2 [2]; vec_t lb3 [1];
  pcbpe_lerp #(.N(3)) u_a1 (.clk_i, .en_i(!stall), .a_i(cp_a), .u_i(ua_q[0]), .r_o(la1));
  pcbpe_lerp #(.N(2)) u_a2 (.clk_i, .en_i(!stall), .a_i(la1), .u_i(ua_q[1]), .r_o(la2));
  pcbpe_lerp #(.N(1)) u_a3 (.clk_i, .en_i(!stall), .a_i(la2), .u_i(ua_q[2]), .r_o(la3));
  pcbpe_lerp #(.N(3)) u_b1 (.clk_i, .en_i(!stall), .a_i(cp_b), .u_i(ub_q[0]), .r_o(lb1));
  pcbpe_lerp #(.N(2)) u_b2 (.clk_i, .en_i(!stall), .a_i(lb1), .u_i(ub_q[1]), .r_o(lb2));
  pcbpe_lerp #(.N(1)) u_b3 (.clk_i, .en_i(!stall), .a_i(lb2), .u_i(ub_q[2]), .r_o(lb3));

  // Pose update at the last stage
  vec_t pos_q, dir_q;
  logic [1:0] ost_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      dir_q <= '{x: '0, y: '0, z: CW'(1 << FB)};
      ost_q <= ST_HELD;
    end else if (!stall && vld_q[NS-2]) begin
      ost_q <= st_q[3];
      if (st_q[3] != ST_HELD) pos_q <= la3[0];
      if (st_q[3] == ST_BOTH) begin
        dir_q.x <= lb3[0].x - la3[0].x;
        dir_q.y <= lb3[0].y - la3[0].y;
        dir_q.z <= lb3[0].z - la3[0].z;
      end
    end
  end
  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata = {6'd0, ost_q, dir_q.z, dir_q.y, dir_q.x, pos_q.z, pos_q.y, pos_q.x};

  `PCB_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall, $stable(vld_q), "pipe moved in stall")
  `PCB_ASSERT_IMP(a_rdy, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "not ready while empty")
endmodule

/* rtl/pcbpe_ram.sv */
// Generic single-write, registered-read RAM.
// No dependencies.
module pcbpe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* rtl/pcbpe_lerp.sv */
// One registered De Casteljau level over a row of 3D points.
// Depends on pcbpe_pkg.
module pcbpe_lerp
  import pcbpe_pkg::*;
#(
  parameter int unsigned N = 3
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  vec_t        a_i [N+1],
  input  logic [FB:0] u_i,
  output vec_t        r_o [N]
);
  function automatic coord_t fmul(coord_t a, logic [FB:0] w);
    logic signed [CW+FB+1:0] p;
    p = a * $signed({1'b0, w});
    return p[CW+FB-1:FB];
  endfunction
  logic [FB:0] um;
  assign um = (FB+1)'(1 << FB) - u_i;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        r_o[i].x <= fmul(a_i[i].x, um) + fmul(a_i[i+1].x, u_i);
        r_o[i].y <= fmul(a_i[i].y, um) + fmul(a_i[i+1].y, u_i);
        r_o[i].z <= fmul(a_i[i].z, um) + fmul(a_i[i+1].z, u_i);
      end
    end
  end
endmodule
